// File: rtl/core/cspu_pkg.sv
// Shared types, constants and bit-order helpers for the CAN signal codec.
// Used by every module under rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package cspu_pkg;

  // Frame geometry and signal limits.
  localparam int FRAME_BYTES     = 8;
  localparam int MAX_SIGNAL_BITS = 64;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

  // Opcodes carried in the input tuser.
  localparam logic OP_DECODE = 1'b0;
  localparam logic OP_ENCODE = 1'b1;

  // Status codes.
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_LAYOUT      = 2'd1;
  localparam logic [1:0] ST_ZERO_FACTOR = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_START_BIT  = 3'd0;
  localparam logic [2:0] REG_SIZE_BITS  = 3'd1;
  localparam logic [2:0] REG_BYTE_ORDER = 3'd2;
  localparam logic [2:0] REG_IS_SIGNED  = 3'd3;
  localparam logic [2:0] REG_FACTOR     = 3'd4;
  localparam logic [2:0] REG_OFFSET     = 3'd5;

  typedef struct packed {
    logic [5:0]  sig_start;
    logic [6:0]  sig_len;
    logic        motorola;
    logic        raw_signed;
    logic [31:0] factor;
    logic [47:0] offset;
  } cfg_t;

  // Classified item handed from the front to the back through the queue.
  typedef struct packed {
    logic [1:0]  status;
    logic        enc;    // encode with a good layout and nonzero factor
    logic        neg;    // sign of raw (decode) or of value minus offset (encode)
    logic [63:0] frame;
    logic [63:0] mag;    // magnitude of raw (decode) or of value minus offset
  } cls_t;

  // Reverse bit order inside every byte: Motorola walk becomes a linear run.
  function automatic logic [63:0] rev_in_bytes(input logic [63:0] f);
    logic [63:0] r;
    for (int k = 0; k < 64; k++) begin
      r[k] = f[(k & 56) | (7 - (k & 7))];
    end
    return r;
  endfunction

  function automatic logic [63:0] rev64(input logic [63:0] f);
    logic [63:0] r;
    for (int k = 0; k < 64; k++) begin
      r[k] = f[63 - k];
    end
    return r;
  endfunction

  // Ones in the low n bits; n of zero gives zero.
  function automatic logic [63:0] wmask(input logic [6:0] n);
    return {64{1'b1}} >> (7'd64 - n);
  endfunction

endpackage

// File: rtl/core/cspu_front.sv
// Front part of the CAN signal codec: layout check, bit gather and sign work.
// Depends on cspu_pkg.
`timescale 1ns / 1ps

module cspu_front (
  input  cspu_pkg::cfg_t  cfg,
  input  logic            opcode,
  input  logic [63:0]     frame_in,
  input  logic [3:0]      frame_length,
  input  logic [63:0]     value_in,
  output cspu_pkg::cls_t  item
);
  import cspu_pkg::*;

  logic [6:0]  lsat;
  logic [9:0]  lim_bits;
  logic [9:0]  last_b;
  logic [3:0]  first;
  logic        ok;
  logic [5:0]  lin_start;
  logic [63:0] tshift;
  logic [63:0] raw;
  logic [63:0] msk;
  logic        rneg;
  logic [63:0] raw_x;
  logic [64:0] dsum;
  logic        fzero;

  // Layout check against the saturated frame length.
  always_comb begin
    lsat = ({3'b0, frame_length} > 7'(FRAME_BYTES)) ? 7'(FRAME_BYTES)
                                                    : {3'b0, frame_length};
    lim_bits = {lsat, 3'b0};
    first    = {1'b0, cfg.sig_start[2:0]} + 4'd1;
    if (!cfg.motorola) begin
      last_b = ({4'b0, cfg.sig_start} + {3'b0, cfg.sig_len} - 10'd1) >> 3;
    end else if ({3'b0, cfg.sig_len} <= {6'b0, first}) begin
      last_b = {7'b0, cfg.sig_start[5:3]};
    end else begin
      last_b = {7'b0, cfg.sig_start[5:3]} +
               (({3'b0, cfg.sig_len} - {6'b0, first} + 10'd7) >> 3);
    end
    ok = (cfg.sig_len != 7'd0) && (cfg.sig_len <= 7'(MAX_SIGNAL_BITS)) &&
         ({4'b0, cfg.sig_start} < lim_bits) && (last_b < {3'b0, lsat});
  end

  // Gather: Intel is a plain shift, Motorola a shift in byte-reversed order.
  always_comb begin
    lin_start = {cfg.sig_start[5:3], ~cfg.sig_start[2:0]};
    msk       = wmask(cfg.sig_len);
    if (!cfg.motorola) begin
      tshift = frame_in >> cfg.sig_start;
      raw    = tshift & msk;
    end else begin
      tshift = rev_in_bytes(frame_in) >> lin_start;
      raw    = rev64(tshift) >> (7'd64 - cfg.sig_len);
    end
    rneg  = cfg.raw_signed && ((raw & ~(msk >> 1)) != 64'd0);
    raw_x = rneg ? (raw | ~msk) : raw;
  end

  // Encode numerator: value minus offset, exact in 65 bits.
  always_comb begin
    dsum  = {value_in[63], value_in} - {{17{cfg.offset[47]}}, cfg.offset};
    fzero = (cfg.factor == 32'd0);
  end

  always_comb begin
    item.frame = frame_in;
    if (!ok) begin
      item.status = ST_LAYOUT;
    end else if (opcode == OP_ENCODE && fzero) begin
      item.status = ST_ZERO_FACTOR;
    end else begin
      item.status = ST_OK;
    end
    item.enc = ok && (opcode == OP_ENCODE) && !fzero;
    if (opcode == OP_ENCODE) begin
      item.neg = dsum[64];
      item.mag = dsum[64] ? (64'd0 - dsum[63:0]) : dsum[63:0];
    end else begin
      item.neg = rneg;
      item.mag = rneg ? (64'd0 - raw_x) : raw_x;
    end
  end

endmodule

// File: rtl/core/cspu_queue.sv
// Short queue between the front and back parts of the CAN signal codec.
// Depends on cspu_pkg for the item type and depth.
`timescale 1ns / 1ps

module cspu_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  cspu_pkg::cls_t  in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output cspu_pkg::cls_t  out_item
);
  import cspu_pkg::*;

  cls_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;

  assign in_ready  = (count != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = mem[rptr];

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// File: rtl/core/cspu_back.sv
// Back part of the CAN signal codec: decode multiply-add with saturation,
// pipelined restoring divider, encode clamp and bit scatter. Depends on cspu_pkg.
`timescale 1ns / 1ps

module cspu_back (
  input  logic            clk,
  input  logic            rst,
  input  cspu_pkg::cfg_t  cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  cspu_pkg::cls_t  in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      status,
  output logic [63:0]     physical_out,
  output logic [63:0]     frame_out
);
  import cspu_pkg::*;

  localparam int DIV_STAGES = 64;

  typedef struct packed {
    logic [1:0]  status;
    logic        enc;
    logic        neg;
    logic [63:0] frame;
    logic [63:0] mag;
    logic [31:0] rem;
    logic [63:0] phys;
  } bk_t;

  logic        en;
  logic        fneg;
  logic [31:0] fmag;

  logic        v1, v2, v3, vc;
  bk_t         s1, s2, s3, sc;
  logic [63:0] p0, p1;
  logic [97:0] ps;

  logic [DIV_STAGES-1:0] vd;
  bk_t                   sd [DIV_STAGES];

  // One restoring step: shift the next dividend bit in, keep the quotient bit.
  function automatic bk_t div_step(input bk_t x, input logic [31:0] d);
    bk_t         y;
    logic [32:0] trial;
    logic        qbit;
    trial = {x.rem, x.mag[63]};
    qbit  = (trial >= {1'b0, d});
    y     = x;
    y.rem = qbit ? 32'(trial - {1'b0, d}) : trial[31:0];
    y.mag = {x.mag[62:0], qbit};
    return y;
  endfunction

  // The whole pipeline advances unless a finished item is held at the output.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign fneg     = cfg.factor[31];
  assign fmag     = fneg ? (32'd0 - cfg.factor) : cfg.factor;

  // Stage 1: two 32x32 partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      s1.status <= in_item.status;
      s1.enc    <= in_item.enc;
      s1.neg    <= in_item.neg;
      s1.frame  <= in_item.frame;
      s1.mag    <= in_item.mag;
      s1.rem    <= '0;
      s1.phys   <= '0;
      p0        <= 64'(in_item.mag[31:0]) * 64'(fmag);
      p1        <= 64'(in_item.mag[63:32]) * 64'(fmag);
    end
  end

  // Stage 2: combine partial products and apply the product sign.
  always_ff @(posedge clk) begin
    logic [95:0] prod;
    prod = {32'd0, p0} + {p1, 32'd0};
    if (en) begin
      s2 <= s1;
      ps <= (s1.neg ^ fneg) ? (98'd0 - {2'b0, prod}) : {2'b0, prod};
    end
  end

  // Stage 3: add the offset and saturate to the signed 64-bit range.
  always_ff @(posedge clk) begin
    logic [97:0] sum;
    logic [63:0] sat;
    bk_t         nx;
    sum = ps + {{50{cfg.offset[47]}}, cfg.offset};
    if (sum[97:63] == {35{sum[97]}}) begin
      sat = sum[63:0];
    end else begin
      sat = sum[97] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    nx      = s2;
    nx.phys = (s2.status == ST_OK && !s2.enc) ? sat : 64'd0;
    if (en) begin
      s3 <= nx;
    end
  end

  // Divider: one quotient bit per stage; mag shifts dividend out, quotient in.
  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= div_step(s3, fmag);
      for (int k = 1; k < DIV_STAGES; k++) begin
        sd[k] <= div_step(sd[k-1], fmag);
      end
    end
  end

  // Clamp the quotient to the signal range.
  always_ff @(posedge clk) begin
    logic [63:0] q;
    logic [63:0] m;
    logic [63:0] lim;
    logic        qneg;
    logic [63:0] r;
    bk_t         nx;
    q    = sd[DIV_STAGES-1].mag;
    m    = wmask(cfg.sig_len);
    lim  = 64'd1 << 6'(cfg.sig_len - 7'd1);
    qneg = (sd[DIV_STAGES-1].neg != fneg) && (q != 64'd0);
    if (cfg.raw_signed) begin
      if (qneg) begin
        r = (64'd0 - ((q > lim) ? lim : q)) & m;
      end else begin
        r = ((q > lim - 64'd1) ? (lim - 64'd1) : q) & m;
      end
    end else begin
      r = qneg ? 64'd0 : ((q > m) ? m : q);
    end
    nx     = sd[DIV_STAGES-1];
    nx.mag = r;
    if (en) begin
      sc <= nx;
    end
  end

  // Output register: scatter raw bits into the frame.
  always_ff @(posedge clk) begin
    logic [63:0] m;
    logic [63:0] fr;
    logic [63:0] dat;
    logic [63:0] msk;
    logic [5:0]  lin_start;
    m         = wmask(cfg.sig_len);
    lin_start = {cfg.sig_start[5:3], ~cfg.sig_start[2:0]};
    if (!cfg.motorola) begin
      msk = m << cfg.sig_start;
      dat = sc.mag << cfg.sig_start;
      fr  = (sc.frame & ~msk) | (dat & msk);
    end else begin
      msk = m << lin_start;
      dat = rev64(sc.mag << (7'd64 - cfg.sig_len)) << lin_start;
      fr  = rev_in_bytes((rev_in_bytes(sc.frame) & ~msk) | (dat & msk));
    end
    if (en) begin
      status       <= sc.status;
      physical_out <= sc.phys;
      frame_out    <= sc.enc ? fr : sc.frame;
    end
  end

  // Valid bits of all stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      vd        <= '0;
      vc        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      vd        <= {vd[DIV_STAGES-2:0], v3};
      vc        <= vd[DIV_STAGES-1];
      out_valid <= vc;
    end
  end

endmodule

// File: rtl/core/can_signal_pack_unpack.sv
// Top level of the CAN signal codec: configuration registers, front, queue, back.
// Depends on cspu_pkg, cspu_front, cspu_queue and cspu_back.
`timescale 1ns / 1ps
//
//  channel  | direction | handshake          | contents
//  ---------+-----------+--------------------+--------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | one frame and opcode per item
//  m_*      | out       | m_tvalid/m_tready  | status, physical value, frame
//  cfg_*    | in        | cfg_valid/cfg_ready| register index and write data
//
//  One item enters per cycle while s_tready is high; each accepted item passes
//  the queue, three multiply-add stages, 64 divider stages, the clamp and
//  the output register.
//  Reset (synchronous) empties the queue and pipeline and loads the register
//  defaults. A stall at m_tready freezes the back pipeline; the four-entry
//  queue then fills and s_tready falls. Configuration writes are always accepted.

module can_signal_pack_unpack (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [135:0]  s_tdata,   // frame_in[63:0], frame_length[67:64],
                                   // value_in[131:68], zero fill
  input  logic          s_tuser,   // opcode
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [127:0]  m_tdata,   // physical_out[63:0], frame_out[127:64]
  output logic [1:0]    m_tuser,   // status
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [47:0]   cfg_data
);
  import cspu_pkg::*;

  cfg_t        cfg;
  cls_t        f_item;
  cls_t        q_item;
  logic        q_valid;
  logic        q_ready;
  logic [63:0] phys;
  logic [63:0] fout;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sig_start  <= 6'd0;
      cfg.sig_len    <= 7'd8;
      cfg.motorola   <= 1'b0;
      cfg.raw_signed <= 1'b0;
      cfg.factor     <= 32'h0001_0000;
      cfg.offset     <= 48'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_START_BIT:  cfg.sig_start  <= cfg_data[5:0];
        REG_SIZE_BITS:  cfg.sig_len    <= cfg_data[6:0];
        REG_BYTE_ORDER: cfg.motorola   <= cfg_data[0];
        REG_IS_SIGNED:  cfg.raw_signed <= cfg_data[0];
        REG_FACTOR:     cfg.factor     <= cfg_data[31:0];
        REG_OFFSET:     cfg.offset     <= cfg_data;
        default: ;
      endcase
    end
  end

  cspu_front u_front (
    .cfg          (cfg),
    .opcode       (s_tuser),
    .frame_in     (s_tdata[63:0]),
    .frame_length (s_tdata[67:64]),
    .value_in     (s_tdata[131:68]),
    .item         (f_item)
  );

  cspu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  cspu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (q_valid),
    .in_ready     (q_ready),
    .in_item      (q_item),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .status       (m_tuser),
    .physical_out (phys),
    .frame_out    (fout)
  );

  assign m_tdata = {fout, phys};

endmodule

// File: rtl/core/cspu_checker.sv
// Port-level checks for the CAN signal codec, bound to the top level.
// Depends on cspu_pkg and can_signal_pack_unpack.
`timescale 1ns / 1ps

module cspu_checker (
  input logic          clk,
  input logic          rst,
  input logic          m_tvalid,
  input logic          m_tready,
  input logic [127:0]  m_tdata,
  input logic [1:0]    m_tuser
);
  import cspu_pkg::*;

  // Reset empties the output.
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result shown right after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Only defined status codes leave the block.
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_LAYOUT ||
                  m_tuser == ST_ZERO_FACTOR))
    else $error("undefined status");

  // Error results carry a zero physical value.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata[63:0] == 64'd0)
    else $error("error result with nonzero value");

endmodule

bind can_signal_pack_unpack cspu_checker u_cspu_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// File: dv/tb_can_signal_pack_unpack.sv
// Self-checking testbench for the CAN signal codec top level can_signal_pack_unpack.
// Depends on cspu_pkg and the RTL under rtl/core; predicts every result in place.
`timescale 1ns / 1ps

module tb_can_signal_pack_unpack;
  import cspu_pkg::*;

  typedef struct {
    logic [1:0]  status;
    logic [63:0] phys;
    logic [63:0] frame;
  } codec_result_t;

  logic          clk;
  logic          rst;
  logic          s_tvalid;
  logic          s_tready;
  logic [135:0]  s_tdata;   // frame_in[63:0], frame_length[67:64], value_in[131:68], zero fill
  logic          s_tuser;   // opcode
  logic          m_tvalid;
  logic          m_tready;
  logic [127:0]  m_tdata;   // physical_out[63:0], frame_out[127:64]
  logic [1:0]    m_tuser;   // status
  logic          cfg_valid;
  logic          cfg_ready;
  logic [2:0]    cfg_index;
  logic [47:0]   cfg_data;

  // Shadow copy of the signal layout and scaling registers.
  logic [5:0]  sh_start;
  logic [6:0]  sh_size;
  logic        sh_motorola;
  logic        sh_signed;
  logic [31:0] sh_factor;
  logic [47:0] sh_offset;

  codec_result_t expected_results[$];
  int unsigned   error_count;
  int unsigned   result_count;
  longint unsigned cycle_count;
  bit          sink_hold;     // long receiver hold-off requested
  int          sink_hold_cycles;
  bit          sink_fast;     // receiver never stalls
  int          sink_gap;      // cycles left in a random long receiver pause

  localparam longint unsigned CYCLE_LIMIT = 2000000;
  localparam int LATENCY = 69;

  can_signal_pack_unpack i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Frame bit position of walk step i for the current layout.
  function automatic int signal_bit_pos(int i);
    int p;
    if (!sh_motorola) return sh_start + i;
    p = sh_start;
    for (int k = 0; k < i; k++) p = (p % 8 == 0) ? p + 15 : p - 1;
    return p;
  endfunction

  function automatic bit layout_valid(int len);
    int s, n, first, lastb;
    s = sh_start;
    n = sh_size;
    if (len > FRAME_BYTES) len = FRAME_BYTES;
    if (n == 0 || n > MAX_SIGNAL_BITS) return 1'b0;
    if (s >= len * 8) return 1'b0;
    if (!sh_motorola) lastb = (s + n - 1) / 8;
    else begin
      first = s % 8 + 1;
      lastb = (n <= first) ? s / 8 : s / 8 + (n - first + 7) / 8;
    end
    return lastb < len;
  endfunction

  // Predicts the codec output for one item with the current shadow registers.
  function automatic codec_result_t predict_codec(logic op, logic [63:0] frame,
                                                  logic [3:0] len, logic [63:0] value);
    codec_result_t r;
    int n, pos;
    logic [63:0] raw;
    logic signed [127:0] wide, dq, lim_hi, lim_lo;
    n = sh_size;
    r.status = ST_OK;
    r.phys = '0;
    r.frame = frame;
    if (!layout_valid(len)) begin
      r.status = ST_LAYOUT;
      return r;
    end
    if (op == OP_DECODE) begin
      raw = '0;
      for (int i = 0; i < n; i++) begin
        pos = signal_bit_pos(i);
        if (pos < 64) raw[sh_motorola ? n - 1 - i : i] = frame[pos];
      end
      if (sh_signed && raw[n-1]) wide = $signed({64'h0, raw}) - (128'sd1 <<< n);
      else wide = $signed({64'h0, raw});
      wide = wide * $signed({{96{sh_factor[31]}}, sh_factor})
           + $signed({{80{sh_offset[47]}}, sh_offset});
      if (wide > 128'sh7FFF_FFFF_FFFF_FFFF) r.phys = 64'h7FFF_FFFF_FFFF_FFFF;
      else if (wide < -(128'sd1 <<< 63)) r.phys = 64'h8000_0000_0000_0000;
      else r.phys = wide[63:0];
      return r;
    end
    if (sh_factor == 32'd0) begin
      r.status = ST_ZERO_FACTOR;
      return r;
    end
    // Division of signed operands truncates toward zero.
    dq = ($signed({{64{value[63]}}, value}) - $signed({{80{sh_offset[47]}}, sh_offset}))
       / $signed({{96{sh_factor[31]}}, sh_factor});
    if (sh_signed) begin
      lim_hi = (128'sd1 <<< (n - 1)) - 1;
      lim_lo = -(128'sd1 <<< (n - 1));
    end else begin
      lim_hi = (128'sd1 <<< n) - 1;
      lim_lo = 0;
    end
    if (dq > lim_hi) dq = lim_hi;
    if (dq < lim_lo) dq = lim_lo;
    raw = dq[63:0];
    for (int i = 0; i < n; i++) begin
      pos = signal_bit_pos(i);
      if (pos < 64) r.frame[pos] = raw[sh_motorola ? n - 1 - i : i];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // Result checker: compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    codec_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      result_count++;
      if (expected_results.size() == 0) report_mismatch("unexpected result", 64'(m_tuser), 64'd0);
      else begin
        e = expected_results.pop_front();
        if (m_tuser !== e.status) report_mismatch("status", 64'(m_tuser), 64'(e.status));
        if (m_tdata[63:0] !== e.phys) report_mismatch("physical", m_tdata[63:0], e.phys);
        if (m_tdata[127:64] !== e.frame) report_mismatch("frame", m_tdata[127:64], e.frame);
      end
    end
  end

  // Receiver ready pattern: mostly short gaps, a few long pauses, and an
  // optional long hold-off.
  always @(negedge clk) begin
    int roll;
    if (rst) m_tready <= 1'b0;
    else if (sink_hold) begin
      m_tready <= 1'b0;
      sink_hold_cycles <= sink_hold_cycles + 1;
      if (sink_hold_cycles >= 300) sink_hold <= 1'b0;
    end else if (sink_fast) m_tready <= 1'b1;
    else if (sink_gap > 0) begin
      m_tready <= 1'b0;
      sink_gap <= sink_gap - 1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 97) m_tready <= (roll < 70);
      else begin
        m_tready <= 1'b0;
        sink_gap <= $urandom_range(10, 40);
      end
    end
  end

  task automatic idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return;
    else if (r < 95) repeat ($urandom_range(1, 3)) @(negedge clk);
    else repeat ($urandom_range(10, 40)) @(negedge clk);
  endtask

  // Sends one item and records its predicted result at acceptance.
  task automatic send_item(logic op, logic [63:0] frame, logic [3:0] len,
                           logic [63:0] value, bit gaps);
    if (gaps) idle_gap();
    s_tvalid = 1'b1;
    s_tuser <= op;
    s_tdata <= {4'h0, value, len, frame};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_results.push_back(predict_codec(op, frame, len, value));
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] data);
    cfg_valid = 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_START_BIT:  sh_start = data[5:0];
      REG_SIZE_BITS:  sh_size = data[6:0];
      REG_BYTE_ORDER: sh_motorola = data[0];
      REG_IS_SIGNED:  sh_signed = data[0];
      REG_FACTOR:     sh_factor = data[31:0];
      REG_OFFSET:     sh_offset = data[47:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_layout(int start, int size, bit moto, bit sgn,
                            logic [31:0] fac, logic [47:0] off);
    write_reg(REG_START_BIT, 48'(start));
    write_reg(REG_SIZE_BITS, 48'(size));
    write_reg(REG_BYTE_ORDER, 48'(moto));
    write_reg(REG_IS_SIGNED, 48'(sgn));
    write_reg(REG_FACTOR, {{16{fac[31]}}, fac});
    write_reg(REG_OFFSET, off);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Values that land near the clamp limits and across both signs.
  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 3))
      0: return rand64();
      1: return {{32{1'b0}}, $urandom()} << $urandom_range(0, 31);
      2: return -({{32{1'b0}}, $urandom()} << $urandom_range(0, 31));
      default: return {24'd0, 8'($urandom_range(0, 255)), 16'd0}
                      - 64'(32768 * $urandom_range(0, 4));
    endcase
  endfunction

  function automatic logic [31:0] pick_factor();
    case ($urandom_range(0, 5))
      0: return 32'h0001_0000;
      1: return 32'hFFFF_0000;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return 32'd0;
      default: return $urandom();
    endcase
  endfunction

  // Reset defaults, extreme field values and every special case.
  task automatic test_directed();
    send_item(OP_DECODE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 64'd0, 1'b0);
    send_item(OP_DECODE, 64'h0, 4'd0, 64'd0, 1'b0);          // layout: empty frame
    send_item(OP_ENCODE, 64'h0, 4'd15, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    send_item(OP_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 64'h8000_0000_0000_0000, 1'b0);
    wait_drained();
    // Full 64-bit signed signal at extreme scale, decode saturates.
    set_layout(0, 64, 1'b0, 1'b1, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF);
    send_item(OP_DECODE, 64'h7FFF_FFFF_FFFF_FFFF, 4'd8, 64'd0, 1'b0);
    send_item(OP_DECODE, 64'h8000_0000_0000_0000, 4'd8, 64'd0, 1'b0);
    send_item(OP_ENCODE, 64'h0, 4'd8, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    send_item(OP_ENCODE, 64'h0, 4'd8, 64'h8000_0000_0000_0000, 1'b0);
    wait_drained();
    // Zero factor on encode and decode; size above the limit.
    set_layout(63, 65, 1'b1, 1'b0, 32'h0, 48'h8000_0000_0000);
    send_item(OP_DECODE, rand64(), 4'd8, 64'd0, 1'b0);
    wait_drained();
    write_reg(REG_SIZE_BITS, 48'd127);
    send_item(OP_ENCODE, rand64(), 4'd8, 64'd0, 1'b0);
    wait_drained();
    write_reg(REG_SIZE_BITS, 48'd0);
    send_item(OP_ENCODE, rand64(), 4'd8, 64'd0, 1'b0);
    wait_drained();
    write_reg(REG_SIZE_BITS, 48'd12);
    write_reg(REG_START_BIT, 48'd7);
    send_item(OP_ENCODE, rand64(), 4'd8, 64'h10000, 1'b0);   // zero factor
    send_item(OP_DECODE, rand64(), 4'd8, 64'd0, 1'b0);       // result is the offset
    send_item(OP_DECODE, rand64(), 4'd1, 64'd0, 1'b0);       // Motorola spills past length
    wait_drained();
  endtask

  // Random layouts, each followed by a burst of mostly well-formed items.
  task automatic test_random_layouts(int items);
    int sent, burst, len;
    logic [63:0] v;
    sent = 0;
    while (sent < items) begin
      wait_drained();
      set_layout($urandom_range(0, 63),
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                 : (($urandom_range(0, 3) == 0) ? $urandom_range(33, 64)
                    : $urandom_range(1, 16)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_factor(),
                 48'({$urandom(), $urandom()}));
      burst = $urandom_range(10, 40);
      for (int i = 0; i < burst && sent < items; i++) begin
        len = ($urandom_range(0, 9) < 8) ? 8 : $urandom_range(0, 15);
        v = pick_value();
        send_item(1'($urandom_range(0, 1)), rand64(), 4'(len), v, !sink_fast);
        sent++;
      end
    end
    wait_drained();
  endtask

  // Receiver holds off while the sender keeps offering, so the input stalls.
  task automatic test_backpressure();
    set_layout(3, 10, 1'b1, 1'b1, 32'h0000_8000, 48'hFFFF_FFF0_0000);
    sink_hold_cycles = 0;
    sink_hold = 1'b1;
    for (int i = 0; i < 120; i++)
      send_item(1'($urandom_range(0, 1)), rand64(), 4'd8, pick_value(), 1'b0);
    wait_drained();
  endtask

  // Back to back items with the receiver always ready.
  task automatic test_streaming();
    sink_fast = 1'b1;
    test_random_layouts(120);
    sink_fast = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_START_BIT;
    cfg_data = '0;
    m_tready = 1'b0;
    sink_hold = 1'b0;
    sink_hold_cycles = 0;
    sink_fast = 1'b0;
    sink_gap = 0;
    error_count = 0;
    result_count = 0;
    cycle_count = 0;
    sh_start = 0;
    sh_size = 8;
    sh_motorola = 0;
    sh_signed = 0;
    sh_factor = 32'h0001_0000;
    sh_offset = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_backpressure();
    test_random_layouts(390);
    test_streaming();
    wait_drained();
    if (error_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
